[rtl/tle_pkg.sv]
// ----------------------------------------------------------------------------
// tle_pkg
// Shared types, constants and echo string table of the terminal line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

    localparam int DATA_W    = 8;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int LIMIT_W   = 6;
    localparam int STR_IDX_W = 3;

    localparam logic OP_START = 1'b0;
    localparam logic OP_CHAR  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ECHO   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PROMPT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_OFF    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_OFF      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_ECHO_OFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_MASK     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LIMIT    = 3'd4;

    localparam logic [CFG_W-1:0]   TERM_MASK_RST  = 32'hFEC0_F8FF;
    localparam logic [LIMIT_W-1:0] LINE_LIMIT_RST = 6'd32;

    localparam logic [DATA_W-1:0] CH_BS     = 8'h08;
    localparam logic [DATA_W-1:0] CH_TAB    = 8'h09;
    localparam logic [DATA_W-1:0] CH_LF     = 8'h0A;
    localparam logic [DATA_W-1:0] CH_CR     = 8'h0D;
    localparam logic [DATA_W-1:0] CH_CTRL_R = 8'h12;
    localparam logic [DATA_W-1:0] CH_CTRL_U = 8'h15;
    localparam logic [DATA_W-1:0] CH_CTRL_X = 8'h18;
    localparam logic [DATA_W-1:0] CH_ESC    = 8'h1B;
    localparam logic [DATA_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [DATA_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [DATA_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [DATA_W-1:0] CH_R      = 8'h52;
    localparam logic [DATA_W-1:0] CH_U      = 8'h55;
    localparam logic [DATA_W-1:0] CH_X      = 8'h58;
    localparam logic [DATA_W-1:0] CH_DEL    = 8'h7F;
    localparam logic [DATA_W-1:0] PRINT_MASK = 8'h60;
    localparam logic [DATA_W-1:0] LOW7_MASK  = 8'h7F;

    typedef struct packed {
        logic              opcode;
        logic [DATA_W-1:0] data;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] out_byte;
        logic              last;
    } out_item_t;

    typedef enum logic [2:0] {
        STR_NONE,
        STR_CRLF,
        STR_DOLLAR,
        STR_KILL_U,
        STR_KILL_X,
        STR_REDRAW,
        STR_ERASE
    } str_sel_t;

    typedef enum logic [1:0] {
        SRC_STR,
        SRC_ZERO,
        SRC_CHAR,
        SRC_RAM
    } out_src_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_STR,
        ST_PROMPT,
        ST_ECHO,
        ST_DUMP_RD,
        ST_DUMP_OUT
    } state_t;

    typedef struct packed {
        logic              take_item;
        logic              store;
        logic              clr_count;
        logic              dec_count;
        logic              dump_start;
        logic              dump_rd;
        logic              dump_adv;
        logic              out_load;
        out_src_t          out_src;
        logic [KIND_W-1:0] out_kind;
        logic              out_last;
        logic [DATA_W-1:0] str_byte;
    } dp_cmd_t;

    typedef struct packed {
        logic opcode;
        logic is_term;
        logic is_cr;
        logic is_esc;
        logic is_kill_u;
        logic is_kill_x;
        logic is_erase;
        logic is_redraw;
        logic echo_ok;
        logic echo_off;
        logic term_sup;
        logic cnt_zero;
        logic limit_hit;
        logic dump_last;
        logic out_free;
    } dp_stat_t;

    function automatic logic [STR_IDX_W-1:0] str_len(input str_sel_t sel);
        logic [STR_IDX_W-1:0] len;
        case (sel)
            STR_CRLF:   len = 3'd2;
            STR_DOLLAR: len = 3'd1;
            STR_KILL_U: len = 3'd5;
            STR_KILL_X: len = 3'd5;
            STR_REDRAW: len = 3'd5;
            STR_ERASE:  len = 3'd3;
            default:    len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [DATA_W-1:0] str_byte(input str_sel_t sel,
                                                   input logic [STR_IDX_W-1:0] idx);
        logic [DATA_W-1:0] letter;
        logic [DATA_W-1:0] b;
        case (sel)
            STR_KILL_X: letter = CH_X;
            STR_REDRAW: letter = CH_R;
            default:    letter = CH_U;
        endcase
        b = '0;
        case (sel)
            STR_CRLF:   b = (idx == 3'd0) ? CH_CR : CH_LF;
            STR_DOLLAR: b = CH_DOLLAR;
            STR_ERASE:  b = (idx == 3'd1) ? CH_SPACE : CH_BS;
            STR_KILL_U, STR_KILL_X, STR_REDRAW:
            begin
                case (idx)
                    3'd0:    b = CH_SPACE;
                    3'd1:    b = CH_CARET;
                    3'd2:    b = letter;
                    3'd3:    b = CH_CR;
                    default: b = CH_LF;
                endcase
            end
            default:    b = '0;
        endcase
        return b;
    endfunction

endpackage

[rtl/terminal_line_editor.sv]
// ----------------------------------------------------------------------------
// terminal_line_editor
// Canonical line editing of one terminal input line, one character a word.
//
// Input channel (in_valid, in_stall, in_data): a start word clears the line
// and yields a prompt request; a character word is stored, erased, echoed or
// ends the line. Output channel (out_valid, out_stall, out_data) carries echo
// bytes, prompt requests and the bytes of a completed line; last marks the
// final output word of each input word.
// Each input word is taken in the idle state and decoded in the decode state,
// then each echo or prompt word is loaded from its own state, and each stored
// byte replayed from the line RAM (one registered read port) passes a read
// state and an output state; in_stall stays high until the last output
// word of the current input word is loaded into the output register.
// A stalled receiver holds the output register and the sequencer waits.
// Reset clears the configuration to its defaults and the character count;
// the line RAM needs no clearing. Write cfg_we/cfg_index/cfg_data only while
// the block is idle.
// ----------------------------------------------------------------------------
module terminal_line_editor #(
    parameter int LINE_DEPTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tle_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  tle_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output tle_pkg::out_item_t             out_data
);

    tle_pkg::dp_cmd_t  cmd;
    tle_pkg::dp_stat_t stat;

    tle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .busy     (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    tle_datapath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

[rtl/tle_ram.sv]
// ----------------------------------------------------------------------------
// tle_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tle_datapath.sv]
// ----------------------------------------------------------------------------
// tle_datapath
// Configuration, item latch, character classes, line store, count and
// output register of the terminal line editor.
// ----------------------------------------------------------------------------
module tle_datapath #(
    parameter int LINE_DEPTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tle_pkg::CFG_W-1:0]      cfg_data,
    input  tle_pkg::in_item_t              in_data,
    input  tle_pkg::dp_cmd_t               cmd,
    output tle_pkg::dp_stat_t              stat,
    output logic                           out_valid,
    input  logic                           out_stall,
    output tle_pkg::out_item_t             out_data
);

    localparam int AW    = $clog2(LINE_DEPTH);
    localparam int CW    = $clog2(LINE_DEPTH + 1);
    localparam int CMP_W = ((CW > tle_pkg::LIMIT_W) ? CW : tle_pkg::LIMIT_W) + 1;

    logic                          filter_off_reg;
    logic                          echo_off_reg;
    logic                          term_echo_off_reg;
    logic [tle_pkg::CFG_W-1:0]     term_mask_reg;
    logic [tle_pkg::LIMIT_W-1:0]   line_limit_reg;

    logic                          opcode_reg;
    logic [tle_pkg::DATA_W-1:0]    char_reg;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic [AW-1:0]                 idx_reg;
    logic [AW-1:0]                 idx_next;
    logic                          out_valid_reg;
    tle_pkg::out_item_t            out_data_reg;

    logic [tle_pkg::DATA_W-1:0]    c;
    logic                          is_ctl;
    logic                          is_term;
    logic                          is_cr;
    logic [tle_pkg::DATA_W-1:0]    store_byte;
    logic [tle_pkg::DATA_W-1:0]    ram_rdata;
    logic [CMP_W-1:0]              eff_limit;
    logic [CMP_W-1:0]              count_inc;
    logic [tle_pkg::DATA_W-1:0]    out_byte_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_off_reg    <= 1'b0;
            echo_off_reg      <= 1'b0;
            term_echo_off_reg <= 1'b0;
            term_mask_reg     <= tle_pkg::TERM_MASK_RST;
            line_limit_reg    <= tle_pkg::LINE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tle_pkg::CFG_FILTER_OFF:    filter_off_reg    <= cfg_data[0];
                tle_pkg::CFG_ECHO_OFF:      echo_off_reg      <= cfg_data[0];
                tle_pkg::CFG_TERM_ECHO_OFF: term_echo_off_reg <= cfg_data[0];
                tle_pkg::CFG_TERM_MASK:     term_mask_reg     <= cfg_data;
                tle_pkg::CFG_LINE_LIMIT:
                    line_limit_reg <= cfg_data[tle_pkg::LIMIT_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            opcode_reg <= in_data.opcode;
            char_reg   <= in_data.data;
        end
        if (cmd.out_load)
        begin
            out_data_reg.kind     <= cmd.out_kind;
            out_data_reg.out_byte <= out_byte_sel;
            out_data_reg.last     <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clr_count)
        begin
            count_next = '0;
        end
        else if (cmd.store)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.dec_count)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.dump_start)
        begin
            idx_next = '0;
        end
        else if (cmd.dump_adv)
        begin
            idx_next = idx_reg + AW'(1);
        end
    end

    assign c          = char_reg;
    assign is_ctl     = (c[7:5] == 3'b000);
    assign is_term    = is_ctl && term_mask_reg[c[4:0]];
    assign is_cr      = (c == tle_pkg::CH_CR);
    assign store_byte = (is_cr && is_term && !filter_off_reg) ? tle_pkg::CH_LF : c;

    always_comb
    begin
        if (line_limit_reg == '0)
        begin
            eff_limit = CMP_W'(1);
        end
        else if (CMP_W'(line_limit_reg) > CMP_W'(LINE_DEPTH))
        begin
            eff_limit = CMP_W'(LINE_DEPTH);
        end
        else
        begin
            eff_limit = CMP_W'(line_limit_reg);
        end
    end

    assign count_inc = CMP_W'(count_reg) + CMP_W'(1);

    always_comb
    begin
        stat.opcode    = opcode_reg;
        stat.is_term   = is_term;
        stat.is_cr     = is_cr;
        stat.is_esc    = (c == tle_pkg::CH_ESC);
        stat.is_kill_u = !filter_off_reg && (c == tle_pkg::CH_CTRL_U);
        stat.is_kill_x = !filter_off_reg && (c == tle_pkg::CH_CTRL_X);
        stat.is_erase  = !filter_off_reg && ((c == tle_pkg::CH_DEL) || (c == tle_pkg::CH_BS));
        stat.is_redraw = !filter_off_reg && (c == tle_pkg::CH_CTRL_R);
        stat.echo_ok   = !echo_off_reg
                         && ((((c & tle_pkg::PRINT_MASK) != '0)
                              && ((c & tle_pkg::LOW7_MASK) != tle_pkg::LOW7_MASK))
                             || (c == tle_pkg::CH_TAB));
        stat.echo_off  = echo_off_reg;
        stat.term_sup  = echo_off_reg || term_echo_off_reg;
        stat.cnt_zero  = (count_reg == '0);
        stat.limit_hit = (count_inc >= eff_limit);
        stat.dump_last = ((CW'(idx_reg) + CW'(1)) == count_reg);
        stat.out_free  = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        case (cmd.out_src)
            tle_pkg::SRC_STR:  out_byte_sel = cmd.str_byte;
            tle_pkg::SRC_CHAR: out_byte_sel = c;
            tle_pkg::SRC_RAM:  out_byte_sel = ram_rdata;
            default:           out_byte_sel = '0;
        endcase
    end

    tle_ram #(
        .WIDTH (tle_pkg::DATA_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (cmd.store),
        .waddr (count_reg[AW-1:0]),
        .wdata (store_byte),
        .re    (cmd.dump_rd),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/tle_ctrl.sv]
// ----------------------------------------------------------------------------
// tle_ctrl
// Sequencer of the terminal line editor: decodes one item into a plan and
// steps through echo string, prompt, echo byte and line dump.
// ----------------------------------------------------------------------------
module tle_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               busy,
    input  tle_pkg::dp_stat_t  stat,
    output tle_pkg::dp_cmd_t   cmd
);

    tle_pkg::state_t                    state_reg;
    tle_pkg::state_t                    state_next;
    tle_pkg::str_sel_t                  str_sel_reg;
    tle_pkg::str_sel_t                  str_sel_next;
    logic [tle_pkg::STR_IDX_W-1:0]      str_idx_reg;
    logic [tle_pkg::STR_IDX_W-1:0]      str_idx_next;
    logic                               prompt_reg;
    logic                               prompt_next;
    logic                               echo_reg;
    logic                               echo_next;
    logic                               dump_reg;
    logic                               dump_next;
    logic                               dump_line_reg;
    logic                               dump_line_next;
    logic                               str_end;

    function automatic tle_pkg::state_t after_str(input logic pr, input logic ec,
                                                  input logic dp);
        tle_pkg::state_t s;
        if (pr)
        begin
            s = tle_pkg::ST_PROMPT;
        end
        else if (ec)
        begin
            s = tle_pkg::ST_ECHO;
        end
        else if (dp)
        begin
            s = tle_pkg::ST_DUMP_RD;
        end
        else
        begin
            s = tle_pkg::ST_IDLE;
        end
        return s;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tle_pkg::ST_IDLE;
            str_sel_reg   <= tle_pkg::STR_NONE;
            str_idx_reg   <= '0;
            prompt_reg    <= 1'b0;
            echo_reg      <= 1'b0;
            dump_reg      <= 1'b0;
            dump_line_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            str_sel_reg   <= str_sel_next;
            str_idx_reg   <= str_idx_next;
            prompt_reg    <= prompt_next;
            echo_reg      <= echo_next;
            dump_reg      <= dump_next;
            dump_line_reg <= dump_line_next;
        end
    end

    assign str_end = (str_idx_reg == (tle_pkg::str_len(str_sel_reg)
                                      - tle_pkg::STR_IDX_W'(1)));

    always_comb
    begin
        state_next     = state_reg;
        str_sel_next   = str_sel_reg;
        str_idx_next   = str_idx_reg;
        prompt_next    = prompt_reg;
        echo_next      = echo_reg;
        dump_next      = dump_reg;
        dump_line_next = dump_line_reg;
        busy           = 1'b1;
        cmd            = '0;
        cmd.out_src    = tle_pkg::SRC_ZERO;
        cmd.out_kind   = tle_pkg::KIND_ECHO;
        cmd.str_byte   = tle_pkg::str_byte(str_sel_reg, str_idx_reg);

        case (state_reg)
            tle_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = tle_pkg::ST_DECODE;
                end
            end

            tle_pkg::ST_DECODE:
            begin
                str_sel_next   = tle_pkg::STR_NONE;
                str_idx_next   = '0;
                prompt_next    = 1'b0;
                echo_next      = 1'b0;
                dump_next      = 1'b0;
                dump_line_next = 1'b0;
                cmd.dump_start = 1'b1;
                if (stat.opcode == tle_pkg::OP_START)
                begin
                    cmd.clr_count = 1'b1;
                    prompt_next   = 1'b1;
                end
                else if (stat.is_term)
                begin
                    if (stat.is_cr && !stat.term_sup)
                    begin
                        str_sel_next = tle_pkg::STR_CRLF;
                    end
                    else if (stat.is_esc && !stat.term_sup)
                    begin
                        str_sel_next = tle_pkg::STR_DOLLAR;
                    end
                    cmd.store      = 1'b1;
                    dump_next      = 1'b1;
                    dump_line_next = 1'b1;
                end
                else if (stat.is_kill_u || stat.is_kill_x)
                begin
                    if (!stat.echo_off)
                    begin
                        str_sel_next = stat.is_kill_u ? tle_pkg::STR_KILL_U
                                                      : tle_pkg::STR_KILL_X;
                    end
                    prompt_next   = 1'b1;
                    cmd.clr_count = 1'b1;
                end
                else if (stat.is_erase)
                begin
                    if (!stat.cnt_zero)
                    begin
                        cmd.dec_count = 1'b1;
                        if (!stat.echo_off)
                        begin
                            str_sel_next = tle_pkg::STR_ERASE;
                        end
                    end
                end
                else if (stat.is_redraw)
                begin
                    if (!stat.echo_off)
                    begin
                        str_sel_next = tle_pkg::STR_REDRAW;
                        prompt_next  = 1'b1;
                        dump_next    = !stat.cnt_zero;
                    end
                end
                else
                begin
                    echo_next      = stat.echo_ok;
                    cmd.store      = 1'b1;
                    dump_next      = stat.limit_hit;
                    dump_line_next = 1'b1;
                end

                if (str_sel_next != tle_pkg::STR_NONE)
                begin
                    state_next = tle_pkg::ST_STR;
                end
                else
                begin
                    state_next = after_str(prompt_next, echo_next, dump_next);
                end
            end

            tle_pkg::ST_STR:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = tle_pkg::SRC_STR;
                    cmd.out_kind = tle_pkg::KIND_ECHO;
                    cmd.out_last = str_end && !prompt_reg && !echo_reg && !dump_reg;
                    if (str_end)
                    begin
                        str_idx_next = '0;
                        state_next   = after_str(prompt_reg, echo_reg, dump_reg);
                    end
                    else
                    begin
                        str_idx_next = str_idx_reg + tle_pkg::STR_IDX_W'(1);
                    end
                end
            end

            tle_pkg::ST_PROMPT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = tle_pkg::SRC_ZERO;
                    cmd.out_kind = tle_pkg::KIND_PROMPT;
                    cmd.out_last = !echo_reg && !dump_reg;
                    state_next   = after_str(1'b0, echo_reg, dump_reg);
                end
            end

            tle_pkg::ST_ECHO:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = tle_pkg::SRC_CHAR;
                    cmd.out_kind = tle_pkg::KIND_ECHO;
                    cmd.out_last = !dump_reg;
                    state_next   = after_str(1'b0, 1'b0, dump_reg);
                end
            end

            tle_pkg::ST_DUMP_RD:
            begin
                cmd.dump_rd = 1'b1;
                state_next  = tle_pkg::ST_DUMP_OUT;
            end

            tle_pkg::ST_DUMP_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = tle_pkg::SRC_RAM;
                    cmd.out_kind = dump_line_reg ? tle_pkg::KIND_LINE : tle_pkg::KIND_ECHO;
                    cmd.out_last = stat.dump_last;
                    if (stat.dump_last)
                    begin
                        cmd.clr_count = dump_line_reg;
                        state_next    = tle_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.dump_adv = 1'b1;
                        state_next   = tle_pkg::ST_DUMP_RD;
                    end
                end
            end

            default:
            begin
                state_next = tle_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[bench/tb_terminal_line_editor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_terminal_line_editor
// Self-checking bench for the terminal line editor. A line model predicts
// the echo, prompt and line words for every accepted input word, and each
// output word is compared field by field with the oldest prediction. A
// directed opening covers every editing code, the terminators and the field
// extremes; random phases then sweep the register settings with random gaps
// on both channels, and one long receiver hold backs the block up.
// ----------------------------------------------------------------------------
module tb_terminal_line_editor;

    localparam int LINE_DEPTH = 32;

    class line_editor_model;
        bit                                filter_off;
        bit                                echo_off;
        bit                                term_echo_off;
        logic [tle_pkg::CFG_W-1:0]         term_mask;
        logic [tle_pkg::LIMIT_W-1:0]       line_limit;
        logic [tle_pkg::DATA_W-1:0]        line_store [LINE_DEPTH];
        int unsigned                       char_count;
        tle_pkg::out_item_t                expected_words [$];
        tle_pkg::out_item_t                step_words [$];
        int                                errors;

        function new();
            filter_off    = 1'b0;
            echo_off      = 1'b0;
            term_echo_off = 1'b0;
            term_mask     = tle_pkg::TERM_MASK_RST;
            line_limit    = tle_pkg::LINE_LIMIT_RST;
            char_count    = 0;
            errors        = 0;
            foreach (line_store[i])
                line_store[i] = '0;
        endfunction

        function void set_reg(logic [tle_pkg::CFG_IDX_W-1:0] idx,
                              logic [tle_pkg::CFG_W-1:0] value);
            case (idx)
                tle_pkg::CFG_FILTER_OFF:    filter_off    = value[0];
                tle_pkg::CFG_ECHO_OFF:      echo_off      = value[0];
                tle_pkg::CFG_TERM_ECHO_OFF: term_echo_off = value[0];
                tle_pkg::CFG_TERM_MASK:     term_mask     = value;
                tle_pkg::CFG_LINE_LIMIT:    line_limit    = value[tle_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void put(logic [tle_pkg::KIND_W-1:0] kind, logic [tle_pkg::DATA_W-1:0] b);
            tle_pkg::out_item_t r;
            r.kind     = kind;
            r.out_byte = b;
            r.last     = 1'b0;
            step_words.push_back(r);
        endfunction

        function void put_tag(logic [tle_pkg::DATA_W-1:0] letter);
            put(tle_pkg::KIND_ECHO, tle_pkg::CH_SPACE);
            put(tle_pkg::KIND_ECHO, tle_pkg::CH_CARET);
            put(tle_pkg::KIND_ECHO, letter);
            put(tle_pkg::KIND_ECHO, tle_pkg::CH_CR);
            put(tle_pkg::KIND_ECHO, tle_pkg::CH_LF);
        endfunction

        function int unsigned limit_now();
            int unsigned lim;
            lim = 32'(line_limit);
            if (lim == 0)
                lim = 1;
            if (lim > LINE_DEPTH)
                lim = LINE_DEPTH;
            return lim;
        endfunction

        function void store(logic [tle_pkg::DATA_W-1:0] c);
            if (char_count < LINE_DEPTH)
            begin
                line_store[char_count] = c;
                char_count++;
            end
        endfunction

        function void flush_line();
            for (int k = 0; k < char_count && k < LINE_DEPTH; k++)
                put(tle_pkg::KIND_LINE, line_store[k]);
            char_count = 0;
        endfunction

        function void note_word(tle_pkg::in_item_t w);
            logic [tle_pkg::DATA_W-1:0] c;
            bit                         quiet_term;
            tle_pkg::out_item_t         tail;
            c = w.data;
            quiet_term = echo_off || term_echo_off;
            step_words.delete();
            if (w.opcode == tle_pkg::OP_START)
            begin
                char_count = 0;
                put(tle_pkg::KIND_PROMPT, '0);
            end
            else if (c < tle_pkg::CH_SPACE && term_mask[c[4:0]])
            begin
                if (c == tle_pkg::CH_CR)
                begin
                    if (!quiet_term)
                    begin
                        put(tle_pkg::KIND_ECHO, tle_pkg::CH_CR);
                        put(tle_pkg::KIND_ECHO, tle_pkg::CH_LF);
                    end
                    if (!filter_off)
                        c = tle_pkg::CH_LF;
                end
                else if (c == tle_pkg::CH_ESC && !quiet_term)
                    put(tle_pkg::KIND_ECHO, tle_pkg::CH_DOLLAR);
                store(c);
                flush_line();
            end
            else if (!filter_off && (c == tle_pkg::CH_CTRL_U || c == tle_pkg::CH_CTRL_X))
            begin
                if (!echo_off)
                    put_tag(c == tle_pkg::CH_CTRL_U ? tle_pkg::CH_U : tle_pkg::CH_X);
                put(tle_pkg::KIND_PROMPT, '0);
                char_count = 0;
            end
            else if (!filter_off && (c == tle_pkg::CH_DEL || c == tle_pkg::CH_BS))
            begin
                if (char_count > 0)
                begin
                    char_count--;
                    if (!echo_off)
                    begin
                        put(tle_pkg::KIND_ECHO, tle_pkg::CH_BS);
                        put(tle_pkg::KIND_ECHO, tle_pkg::CH_SPACE);
                        put(tle_pkg::KIND_ECHO, tle_pkg::CH_BS);
                    end
                end
            end
            else if (!filter_off && c == tle_pkg::CH_CTRL_R)
            begin
                if (!echo_off)
                begin
                    put_tag(tle_pkg::CH_R);
                    put(tle_pkg::KIND_PROMPT, '0);
                    for (int k = 0; k < char_count && k < LINE_DEPTH; k++)
                        put(tle_pkg::KIND_ECHO, line_store[k]);
                end
            end
            else
            begin
                if (!echo_off
                    && ((((c & tle_pkg::PRINT_MASK) != 0)
                         && ((c & tle_pkg::LOW7_MASK) != tle_pkg::LOW7_MASK))
                        || c == tle_pkg::CH_TAB))
                    put(tle_pkg::KIND_ECHO, c);
                store(c);
                if (char_count >= limit_now())
                    flush_line();
            end
            if (step_words.size() > 0)
            begin
                tail = step_words.pop_back();
                tail.last = 1'b1;
                step_words.push_back(tail);
            end
            foreach (step_words[k])
                expected_words.push_back(step_words[k]);
        endfunction

        function void check_word(tle_pkg::out_item_t got);
            tle_pkg::out_item_t want;
            if (expected_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, %s",
                         $realtime, "got:");
                $display("    kind=%0d byte=%02h last=%0d",
                         got.kind, got.out_byte, got.last);
                return;
            end
            want = expected_words.pop_front();
            if (got.kind !== want.kind || got.out_byte !== want.out_byte
                || got.last !== want.last)
            begin
                errors++;
                $display("%0t: mismatch, expected kind=%0d byte=%02h last=%0d,",
                         $realtime, want.kind, want.out_byte, want.last);
                $display("    got kind=%0d byte=%02h last=%0d",
                         got.kind, got.out_byte, got.last);
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [tle_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [tle_pkg::CFG_W-1:0]       cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    tle_pkg::in_item_t               in_data;
    logic                            out_valid;
    logic                            out_stall;
    tle_pkg::out_item_t              out_data;

    line_editor_model   model;
    bit                 no_idle;
    bit                 long_hold_req;

    terminal_line_editor #(
        .LINE_DEPTH(LINE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int idle_gap();
        if (no_idle)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic tle_pkg::in_item_t random_word();
        tle_pkg::in_item_t w;
        int                pick;
        pick = $urandom_range(0, 99);
        w.opcode = tle_pkg::OP_CHAR;
        w.data = tle_pkg::DATA_W'($urandom_range(32, 126));
        if (pick < 8)
        begin
            w.opcode = tle_pkg::OP_START;
            w.data = tle_pkg::DATA_W'($urandom_range(0, 255));
        end
        else if (pick < 55)
            ;
        else if (pick < 63)
            w.data = tle_pkg::DATA_W'($urandom_range(128, 255));
        else if (pick < 75)
        begin
            case ($urandom_range(0, 4))
                0:       w.data = tle_pkg::CH_BS;
                1:       w.data = tle_pkg::CH_DEL;
                2:       w.data = tle_pkg::CH_CTRL_R;
                3:       w.data = tle_pkg::CH_CTRL_U;
                default: w.data = tle_pkg::CH_CTRL_X;
            endcase
        end
        else if (pick < 85)
            w.data = $urandom_range(0, 1) ? tle_pkg::CH_CR : tle_pkg::CH_ESC;
        else if (pick < 92)
            w.data = tle_pkg::DATA_W'($urandom_range(0, 31));
        else
            w.data = tle_pkg::DATA_W'($urandom_range(0, 255));
        return w;
    endfunction

    task automatic send_word(input tle_pkg::in_item_t w);
        int gap;
        gap = idle_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (in_stall !== 1'b0);
        model.note_word(w);
    endtask

    task automatic send_char(input logic [tle_pkg::DATA_W-1:0] c);
        tle_pkg::in_item_t w;
        w.opcode = tle_pkg::OP_CHAR;
        w.data   = c;
        send_word(w);
    endtask

    task automatic send_start(input logic [tle_pkg::DATA_W-1:0] junk);
        tle_pkg::in_item_t w;
        w.opcode = tle_pkg::OP_START;
        w.data   = junk;
        send_word(w);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (model.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic [tle_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tle_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        model.set_reg(idx, value);
    endtask

    task automatic run_phase(input bit f, input bit e, input bit t,
                             input logic [tle_pkg::CFG_W-1:0] mask,
                             input logic [tle_pkg::LIMIT_W-1:0] lim,
                             input int count, input bit quiet, input bit hold_out);
        wait_idle();
        write_reg(tle_pkg::CFG_FILTER_OFF, tle_pkg::CFG_W'(f));
        write_reg(tle_pkg::CFG_ECHO_OFF, tle_pkg::CFG_W'(e));
        write_reg(tle_pkg::CFG_TERM_ECHO_OFF, tle_pkg::CFG_W'(t));
        write_reg(tle_pkg::CFG_TERM_MASK, mask);
        write_reg(tle_pkg::CFG_LINE_LIMIT, tle_pkg::CFG_W'(lim));
        no_idle = quiet;
        long_hold_req = hold_out;
        repeat (count) send_word(random_word());
    endtask

    // receiver: random hold before each word, one long hold on request
    initial
    begin
        int hold;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            hold = idle_gap();
            if (long_hold_req)
            begin
                hold = 400;
                long_hold_req = 1'b0;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            model.check_word(out_data);
        end
    end

    initial
    begin
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        model         = new();
        no_idle       = 1'b0;
        long_hold_req = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_data       = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_start(8'h00);
        send_char(8'h61);
        send_char(8'h7E);
        send_char(8'hFF);
        send_char(8'h80);
        send_char(tle_pkg::CH_TAB);
        send_char(tle_pkg::CH_SPACE);
        send_char(tle_pkg::CH_DEL);
        send_char(tle_pkg::CH_BS);
        send_char(tle_pkg::CH_CTRL_R);
        send_char(tle_pkg::CH_CTRL_U);
        send_char(8'h62);
        send_char(tle_pkg::CH_CTRL_X);
        send_char(tle_pkg::CH_BS);
        send_char(8'h63);
        send_char(tle_pkg::CH_CR);
        send_char(8'h64);
        send_char(tle_pkg::CH_ESC);
        send_char(8'h01);
        send_char(8'h00);
        send_start(8'hFF);
        send_char(8'h41);
        send_char(tle_pkg::CH_LF);

        // lower the limit under a partly typed line
        wait_idle();
        write_reg(tle_pkg::CFG_LINE_LIMIT, tle_pkg::CFG_W'(2));
        send_char(8'h65);
        send_char(8'h66);
        send_char(8'h67);

        run_phase(1'b1, 1'b0, 1'b0, $urandom(), 6'd8, 20, 1'b0, 1'b0);
        run_phase(1'b0, 1'b1, 1'b0, tle_pkg::TERM_MASK_RST, 6'd0, 12, 1'b0, 1'b0);
        run_phase(1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 6'd63, 20, 1'b0, 1'b0);
        run_phase(1'b0, 1'b0, 1'b0, 32'h0000_0000, 6'd5, 30, 1'b1, 1'b0);
        run_phase(1'b1, 1'b1, 1'b1, $urandom(), 6'd32, 25, 1'b0, 1'b0);
        run_phase(1'b0, 1'b0, 1'b0, tle_pkg::TERM_MASK_RST, 6'd20, 40, 1'b1, 1'b1);
        run_phase(1'b0, 1'b0, 1'b0, tle_pkg::TERM_MASK_RST, 6'd1, 10, 1'b0, 1'b0);

        wait_idle();
        if (model.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
